// ===== rtl/ncc_pkg.sv =====
`default_nettype none

package ncc_pkg;

    // Table size and channel precision.
    localparam int CLASS_COUNT = 6;
    localparam int CHANNEL_BITS = 16;

    // Field widths fixed by the interface.
    localparam int OP_W = 1;
    localparam int INDEX_W = 3;
    localparam int PORT_CHAN_W = 16;

    // Derived widths.
    localparam int CLASS_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int CHAN_COUNT = 3;
    localparam int FRAC_SHIFT = 8;
    localparam int NUM_W = CHANNEL_BITS + FRAC_SHIFT;
    localparam int QUOT_W = 16;
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_STEPS = QUOT_W / BITS_PER_STEP;
    localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int SQ_W = 2 * QUOT_W;
    localparam int SUM_W = SQ_W + 2;

    // Operation codes of the op field.
    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_CLASSIFY = 1'b1;

    // Color channel selector.
    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 load;
        logic                 capture;
        logic                 setup;
        logic                 div_step;
        logic                 square;
        logic                 accum;
        logic                 compare;
        logic                 first_class;
        logic                 report;
        logic [CLASS_W-1:0]   class_sel;
        chan_t                chan_sel;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ncc_ctrl.sv =====
`default_nettype none

module ncc_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [ncc_pkg::OP_W-1:0]          op,
    output ncc_pkg::cmd_t                          cmd,
    output logic                                   busy
);

    typedef enum logic [2:0] {
        IDLE,
        SETUP,
        DIVIDE,
        SQUARE,
        ACCUM,
        COMPARE,
        REPORT
    } state_t;

    localparam logic [ncc_pkg::CLASS_W-1:0] LAST_CLASS =
        ncc_pkg::CLASS_W'(ncc_pkg::CLASS_COUNT - 1);
    localparam logic [ncc_pkg::STEP_W-1:0] LAST_STEP =
        ncc_pkg::STEP_W'(ncc_pkg::DIV_STEPS - 1);

    state_t                          state_reg;
    state_t                          state_next;
    logic [ncc_pkg::CLASS_W-1:0]     class_reg;
    logic [ncc_pkg::CLASS_W-1:0]     class_next;
    ncc_pkg::chan_t                  chan_reg;
    ncc_pkg::chan_t                  chan_next;
    logic [ncc_pkg::STEP_W-1:0]      step_reg;
    logic [ncc_pkg::STEP_W-1:0]      step_next;
    logic                            busy_reg;
    logic                            accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        class_next = class_reg;
        chan_next  = chan_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.class_sel = class_reg;
        cmd.chan_sel  = chan_reg;
        case (state_reg)
            IDLE:
            begin
                if (accept && (op == ncc_pkg::OP_CLASSIFY))
                begin
                    cmd.capture = 1'b1;
                    class_next  = '0;
                    chan_next   = ncc_pkg::CH_RED;
                    state_next  = SETUP;
                end
                else if (accept)
                begin
                    cmd.load = 1'b1;
                end
            end
            SETUP:
            begin
                cmd.setup  = 1'b1;
                step_next  = '0;
                state_next = DIVIDE;
            end
            DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = SQUARE;
                end
            end
            SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ACCUM;
            end
            ACCUM:
            begin
                cmd.accum = 1'b1;
                if (chan_reg == ncc_pkg::CH_BLUE)
                begin
                    state_next = COMPARE;
                end
                else
                begin
                    chan_next  = ncc_pkg::chan_t'(chan_reg + 2'd1);
                    state_next = SETUP;
                end
            end
            COMPARE:
            begin
                cmd.compare     = 1'b1;
                cmd.first_class = (class_reg == '0);
                chan_next       = ncc_pkg::CH_RED;
                if (class_reg == LAST_CLASS)
                begin
                    state_next = REPORT;
                end
                else
                begin
                    class_next = class_reg + 1'b1;
                    state_next = SETUP;
                end
            end
            REPORT:
            begin
                cmd.report = 1'b1;
                state_next = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            class_reg <= '0;
            chan_reg  <= ncc_pkg::CH_RED;
            step_reg  <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            class_reg <= class_next;
            chan_reg  <= chan_next;
            step_reg  <= step_next;
            busy_reg  <= (state_next != IDLE);
        end
    end

    assign busy = busy_reg;

`ifndef SYNTHESIS
    // The class counter never walks past the last table entry.
    a_class_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(class_reg) < ncc_pkg::CLASS_COUNT)
        else $error("class counter out of range");

    // An accepted classify beat makes the block busy on the next cycle.
    a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == ncc_pkg::OP_CLASSIFY)) |=> busy_reg)
        else $error("classify beat did not start the sequencer");

    // A load beat completes in its own cycle and leaves the block idle.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == ncc_pkg::OP_LOAD)) |=> !busy_reg)
        else $error("load beat made the block busy");

    // The result is reported only after the last class has been compared.
    a_report_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == REPORT) |-> ($past(state_reg) == COMPARE)
            && ($past(class_reg) == LAST_CLASS))
        else $error("report without a full class sweep");
`endif

endmodule

`default_nettype wire

// ===== rtl/ncc_dpath.sv =====
`default_nettype none

module ncc_dpath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire ncc_pkg::cmd_t                         cmd,
    input  wire logic [ncc_pkg::INDEX_W-1:0]           class_index,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       red_level,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       green_level,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       blue_level,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       red_spread,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       green_spread,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       blue_spread,
    output logic                                       done,
    output logic [ncc_pkg::INDEX_W-1:0]                nearest_class
);

    localparam int CB = ncc_pkg::CHANNEL_BITS;
    localparam int QW = ncc_pkg::QUOT_W;

    // Class table: reset to zero means and zero spreads.
    logic [CB-1:0] means_reg   [ncc_pkg::CLASS_COUNT][ncc_pkg::CHAN_COUNT];
    logic [CB-1:0] spreads_reg [ncc_pkg::CLASS_COUNT][ncc_pkg::CHAN_COUNT];

    logic [CB-1:0] in_level  [ncc_pkg::CHAN_COUNT];
    logic [CB-1:0] in_spread [ncc_pkg::CHAN_COUNT];
    logic [CB-1:0] sample_reg [ncc_pkg::CHAN_COUNT];
    logic          load_hit;
    logic [ncc_pkg::CLASS_W-1:0] load_sel;

    // Term setup.
    logic [CB-1:0] sample_sel;
    logic [CB-1:0] mean_sel;
    logic [CB-1:0] spread_sel;
    logic [CB-1:0] diff;
    logic [CB-1:0] den;
    logic [ncc_pkg::NUM_W-1:0] num_full;

    // Divider.
    logic [CB-1:0] den_reg;
    logic [CB-1:0] rem_reg;
    logic [CB-1:0] rem_next;
    logic [QW-1:0] num_reg;
    logic [QW-1:0] num_next;
    logic [QW-1:0] quot_reg;
    logic [QW-1:0] quot_next;
    logic          sat_reg;
    logic [CB:0]   trial;
    logic [QW-1:0] quot_eff;

    // Square, sum and best-so-far.
    logic [ncc_pkg::SQ_W-1:0]  prod_reg;
    logic [ncc_pkg::SUM_W-1:0] sum_reg;
    logic [ncc_pkg::SUM_W-1:0] best_reg;
    logic [ncc_pkg::CLASS_W-1:0] best_class_reg;
    logic                        done_reg;
    logic [ncc_pkg::INDEX_W-1:0] result_reg;

    assign in_level[0]  = CB'(red_level);
    assign in_level[1]  = CB'(green_level);
    assign in_level[2]  = CB'(blue_level);
    assign in_spread[0] = CB'(red_spread);
    assign in_spread[1] = CB'(green_spread);
    assign in_spread[2] = CB'(blue_spread);

    assign load_hit = cmd.load && (32'(class_index) < ncc_pkg::CLASS_COUNT);
    assign load_sel = ncc_pkg::CLASS_W'(class_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < ncc_pkg::CLASS_COUNT; c++)
            begin
                for (int k = 0; k < ncc_pkg::CHAN_COUNT; k++)
                begin
                    means_reg[c][k]   <= '0;
                    spreads_reg[c][k] <= '0;
                end
            end
        end
        else if (load_hit)
        begin
            for (int k = 0; k < ncc_pkg::CHAN_COUNT; k++)
            begin
                means_reg[load_sel][k]   <= in_level[k];
                spreads_reg[load_sel][k] <= in_spread[k];
            end
        end
    end

    // The quotient saturates exactly when diff >= 256 * den; otherwise the
    // integer part of diff / 256 is already a valid partial remainder and
    // only the sixteen low quotient bits remain to be found.
    assign sample_sel = sample_reg[cmd.chan_sel];
    assign mean_sel   = means_reg[cmd.class_sel][cmd.chan_sel];
    assign spread_sel = spreads_reg[cmd.class_sel][cmd.chan_sel];
    assign diff       = (sample_sel >= mean_sel) ? (sample_sel - mean_sel)
                                                 : (mean_sel - sample_sel);
    assign den        = (spread_sel == '0) ? CB'(1) : spread_sel;
    assign num_full   = {diff, {ncc_pkg::FRAC_SHIFT{1'b0}}};

    // Restoring division, several quotient bits per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        trial     = '0;
        for (int i = 0; i < ncc_pkg::BITS_PER_STEP; i++)
        begin
            trial = {rem_next, num_next[QW-1]};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = CB'(trial - {1'b0, den_reg});
                quot_next = {quot_next[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[CB-1:0];
                quot_next = {quot_next[QW-2:0], 1'b0};
            end
            num_next = {num_next[QW-2:0], 1'b0};
        end
    end

    assign quot_eff = sat_reg ? {QW{1'b1}} : quot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int k = 0; k < ncc_pkg::CHAN_COUNT; k++)
            begin
                sample_reg[k] <= in_level[k];
            end
            sum_reg <= '0;
        end
        if (cmd.setup)
        begin
            den_reg  <= den;
            sat_reg  <= ((diff >> ncc_pkg::FRAC_SHIFT) >= den);
            rem_reg  <= CB'(num_full >> QW);
            num_reg  <= num_full[QW-1:0];
            quot_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            quot_reg <= quot_next;
        end
        if (cmd.square)
        begin
            prod_reg <= quot_eff * quot_eff;
        end
        if (cmd.accum)
        begin
            sum_reg <= sum_reg + ncc_pkg::SUM_W'(prod_reg);
        end
        if (cmd.compare)
        begin
            if (cmd.first_class || (sum_reg < best_reg))
            begin
                best_reg       <= sum_reg;
                best_class_reg <= cmd.class_sel;
            end
            sum_reg <= '0;
        end
        if (cmd.report)
        begin
            result_reg <= ncc_pkg::INDEX_W'(best_class_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.report;
        end
    end

    assign done          = done_reg;
    assign nearest_class = result_reg;

endmodule

`default_nettype wire

// ===== rtl/nearest_color_class_top.sv =====
`default_nettype none

// Nearest color class: a six-entry table of per-class red, green and blue
// means and spreads (unsigned Q0.16), and a classifier that returns the class
// whose normalized squared distance sum(((sample - mean) / spread)^2) to a
// sample is smallest, the lower index winning ties. A beat is taken at a
// rising edge where start is high and busy is low. A load beat (op = 0)
// writes the table entry named by class_index in that same cycle, gives no
// result and leaves busy low, so loads may follow one another every cycle;
// an index past the last class is ignored. A classify beat (op = 1) raises
// busy while every class is swept, and nearest_class then appears with done
// high for exactly one cycle, the first cycle in which busy is low again; a
// new beat may be taken in that same cycle. The receiver cannot stall: the
// result must be taken in its done cycle. The sweep is paced by the single
// shared divider, which finds four quotient bits a cycle for each of the
// eighteen class and channel terms, with a step each to set up the term,
// square the Q8.8 quotient and add it to the class sum, and a step per class
// to compare against the best sum so far. A spread of zero counts as one
// least significant bit, and each quotient saturates at 255.996.
// After reset the table holds zero means and zero spreads.
module nearest_color_class_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [ncc_pkg::OP_W-1:0]              op,
    input  wire logic [ncc_pkg::INDEX_W-1:0]           class_index,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       red_level,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       green_level,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       blue_level,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       red_spread,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       green_spread,
    input  wire logic [ncc_pkg::PORT_CHAN_W-1:0]       blue_spread,
    output logic                                       done,
    output logic [ncc_pkg::INDEX_W-1:0]                nearest_class
);

    // Command bundle from the sequencer; it selects the class and channel
    // being worked on and steps the datapath through setup, divide, square and
    // accumulate for each term and compare for each class.
    ncc_pkg::cmd_t cmd;

    // The sequencer decodes the beat and walks all classes and channels.
    ncc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath holds the class table, the sample, the shared divider,
    // the squarer, the class sum and the best class so far.
    ncc_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .class_index   (class_index),
        .red_level     (red_level),
        .green_level   (green_level),
        .blue_level    (blue_level),
        .red_spread    (red_spread),
        .green_spread  (green_spread),
        .blue_spread   (blue_spread),
        .done          (done),
        .nearest_class (nearest_class)
    );

endmodule

`default_nettype wire
